/* rtl/core/vnf_pkg.sv */
// Shared types, constants and helper functions for the value-noise fBm core.
`timescale 1ns / 1ps
`default_nettype none
package vnf_pkg;

  localparam int FRAC_BITS = 24;

  typedef logic [FRAC_BITS-1:0] q24_t;

  // 2.03 in Q16
  localparam logic [17:0] SCALE_Q16 = 18'd133038;
  // 0.1031 in Q0.32
  localparam logic [31:0] HASH_MUL  = 32'd442811128;
  // 33.33 in Q.24
  localparam logic [29:0] HASH_ADD  = 30'd559184609;
  // 1.0 in Q1.24 and 3.0 in Q2.24
  localparam logic [24:0] ONE_Q24   = 25'd16777216;
  localparam logic [25:0] THREE_Q24 = 26'd50331648;

  // per-axis octave offsets 17.1, 31.7, 11.3 in Q16
  localparam logic signed [21:0] OCT_OFFSET [3] = '{22'sd1120666, 22'sd2077491, 22'sd740557};

  // top 24 bits of the wrapped 32-bit lattice product
  function automatic q24_t corner_frac(input logic [31:0] n);
    logic [31:0] q;
    q = n * HASH_MUL;
    return q[31:8];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/value_noise_fbm_3d_core.sv */
// Top level of the fractal 3D value-noise core: octave chain and normalizer.
//
// Usage: present a sample point (signed Q16.16 x, y, z) on the in_ channel
// with valid/ready; one word comes back on the out_ channel carrying the
// normalized fBm value as unsigned Q0.16.
// Each octave is a 12-stage pipeline (cell split and lattice hash inputs,
// five hash stages, three blend levels of multiply then add); octaves are
// chained, each handing the scaled/offset point and the running sum to the
// next. A two-stage restoring divider by (2^OCTAVES - 1) follows.
// Throughput: one word per cycle; a new point is taken every cycle while
// the output is free or being taken.
// Stall: the whole pipeline freezes while out_valid is high and out_ready
// is low; in_ready drops at the same time, so nothing is lost or repeated.
// Reset: synchronous, active low; clears all valid bits only, the data
// path holds whatever it had. No configuration.
`timescale 1ns / 1ps
`default_nettype none
module value_noise_fbm_3d_core #(
  parameter int OCTAVES = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_noise_value
);

  // point width covers 2.03x growth per octave; sum width one bit per octave
  localparam int PW = OCTAVES + 34;
  localparam int AW = OCTAVES + 24;

  logic en;

  logic                 v_c   [OCTAVES+1];
  logic signed [PW-1:0] px_c  [OCTAVES+1];
  logic signed [PW-1:0] py_c  [OCTAVES+1];
  logic signed [PW-1:0] pz_c  [OCTAVES+1];
  logic [AW-1:0]        acc_c [OCTAVES+1];

  // global advance: hold everything while a finished word waits
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign v_c[0]   = in_valid;
  assign px_c[0]  = PW'(in_point_x);
  assign py_c[0]  = PW'(in_point_y);
  assign pz_c[0]  = PW'(in_point_z);
  assign acc_c[0] = '0;

  for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
    vnf_octave #(
      .PW (PW),
      .AW (AW)
    ) u_octave (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (v_c[o]),
      .in_px     (px_c[o]),
      .in_py     (py_c[o]),
      .in_pz     (pz_c[o]),
      .in_acc    (acc_c[o]),
      .out_valid (v_c[o+1]),
      .out_px    (px_c[o+1]),
      .out_py    (py_c[o+1]),
      .out_pz    (pz_c[o+1]),
      .out_acc   (acc_c[o+1])
    );
  end

  // final octave's next point is unused downstream
  vnf_norm #(
    .OCTAVES (OCTAVES)
  ) u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_c[OCTAVES]),
    .in_acc    (acc_c[OCTAVES]),
    .out_valid (out_valid),
    .out_noise (out_noise_value)
  );

endmodule
`default_nettype wire

/* rtl/core/vnf_hash.sv */
// Five-stage pipelined corner hash: three Q0.24 axis values to one Q0.24 value.
`timescale 1ns / 1ps
`default_nettype none
module vnf_hash (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire vnf_pkg::q24_t a,
  input  wire vnf_pkg::q24_t b,
  input  wire vnf_pkg::q24_t c,
  output vnf_pkg::q24_t      h
);

  logic [47:0] ab_r, bc_r, ca_r;
  logic [55:0] ks_r;
  logic [24:0] ab1_r, ab2_r;
  vnf_pkg::q24_t c1_r, c2_r;
  logic [31:0] d_r;
  logic [33:0] s_r;
  logic [32:0] z_r;
  logic [47:0] pp0_r;
  logic [31:0] pp1_r;
  vnf_pkg::q24_t h_r;

  logic [25:0] abc_sum;
  logic [56:0] tot;
  logic [47:0] fin;

  assign abc_sum = 26'(a) + 26'(b) + 26'(c);
  assign tot     = 57'(ab_r) + 57'(bc_r) + 57'(ca_r) + 57'(ks_r);
  assign fin     = pp0_r + {pp1_r, 16'h0000};

  always_ff @(posedge clk) begin
    if (en) begin
      ab_r  <= 48'(a) * 48'(b);
      bc_r  <= 48'(b) * 48'(c);
      ca_r  <= 48'(c) * 48'(a);
      ks_r  <= 56'(abc_sum) * 56'(vnf_pkg::HASH_ADD);
      ab1_r <= 25'(a) + 25'(b);
      c1_r  <= c;
      d_r   <= tot[55:24];
      ab2_r <= ab1_r;
      c2_r  <= c1_r;
      s_r   <= 34'(ab2_r) + {1'b0, d_r, 1'b0};
      z_r   <= 33'(c2_r) + 33'(d_r);
      // only the low 48 bits of the product matter
      pp0_r <= 48'(s_r) * 48'(z_r[15:0]);
      pp1_r <= s_r[31:0] * 32'(z_r[32:16]);
      h_r   <= fin[47:24];
    end
  end

  assign h = h_r;

endmodule
`default_nettype wire

/* rtl/core/vnf_octave.sv */
// One octave: lattice split, smoothstep, eight corner hashes, trilinear blend, next point.
`timescale 1ns / 1ps
`default_nettype none
module vnf_octave #(
  parameter int PW = 39,
  parameter int AW = 29
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [PW-1:0] in_px,
  input  wire logic signed [PW-1:0] in_py,
  input  wire logic signed [PW-1:0] in_pz,
  input  wire logic [AW-1:0]        in_acc,
  output logic                      out_valid,
  output logic signed [PW-1:0]      out_px,
  output logic signed [PW-1:0]      out_py,
  output logic signed [PW-1:0]      out_pz,
  output logic [AW-1:0]             out_acc
);

  localparam int LAT = 12;

  logic signed [PW-1:0] p_in [3];
  assign p_in[0] = in_px;
  assign p_in[1] = in_py;
  assign p_in[2] = in_pz;

  // stage 0 combinational
  vnf_pkg::q24_t        fr0_c [3];
  vnf_pkg::q24_t        fr1_c [3];
  vnf_pkg::q24_t        f_c   [3];
  vnf_pkg::q24_t        ff_c  [3];
  logic signed [PW+18:0] prod_c [3];

  always_comb begin
    logic [31:0] lat_pt;
    logic [47:0] sq;
    for (int k = 0; k < 3; k++) begin
      lat_pt    = {{(48-PW){p_in[k][PW-1]}}, p_in[k][PW-1:16]};
      fr0_c[k]  = vnf_pkg::corner_frac(lat_pt);
      fr1_c[k]  = vnf_pkg::corner_frac(lat_pt + 32'd1);
      f_c[k]    = {p_in[k][15:0], 8'h00};
      sq        = 48'(f_c[k]) * 48'(f_c[k]);
      ff_c[k]   = sq[47:24];
      prod_c[k] = p_in[k] * $signed({1'b0, vnf_pkg::SCALE_Q16});
    end
  end

  logic [LAT-1:0]        v_r;
  vnf_pkg::q24_t         fr0_r [3];
  vnf_pkg::q24_t         fr1_r [3];
  vnf_pkg::q24_t         f_r   [3];
  vnf_pkg::q24_t         ff_r  [3];
  logic signed [PW+18:0] prod_r [3];
  logic [AW-1:0]         acc_p [0:10];
  vnf_pkg::q24_t [2:0]   u_p   [1:9];
  logic signed [PW-1:0]  np_p  [1:11][3];
  logic [48:0]           xa_r [4];
  logic [47:0]           xb_r [4];
  vnf_pkg::q24_t         xv_r [4];
  logic [48:0]           ya_r [2];
  logic [47:0]           yb_r [2];
  vnf_pkg::q24_t         yv_r [2];
  logic [48:0]           za_r;
  logic [47:0]           zb_r;
  logic [AW-1:0]         acc_out_r;

  vnf_pkg::q24_t         h [8];

  // stage 1 combinational: smoothstep and point update
  vnf_pkg::q24_t         u_c  [3];
  logic signed [PW-1:0]  np_c [3];

  always_comb begin
    logic [49:0]           w;
    logic signed [PW+18:0] t;
    for (int k = 0; k < 3; k++) begin
      w       = 50'(ff_r[k]) * 50'(vnf_pkg::THREE_Q24 - {1'b0, f_r[k], 1'b0});
      u_c[k]  = w[47:24];
      t       = (prod_r[k] >>> 16) + vnf_pkg::OCT_OFFSET[k];
      np_c[k] = t[PW-1:0];
    end
  end

  // corner i: bit 0 picks x+1, bit 1 y+1, bit 2 z+1
  for (genvar i = 0; i < 8; i++) begin : g_hash
    vnf_hash u_hash (
      .clk (clk),
      .en  (en),
      .a   (((i % 2) == 1)       ? fr1_r[0] : fr0_r[0]),
      .b   ((((i / 2) % 2) == 1) ? fr1_r[1] : fr0_r[1]),
      .c   ((((i / 4) % 2) == 1) ? fr1_r[2] : fr0_r[2]),
      .h   (h[i])
    );
  end

  logic [48:0] xsum [4];
  logic [48:0] ysum [2];
  logic [48:0] zsum;

  always_comb begin
    for (int j = 0; j < 4; j++) xsum[j] = xa_r[j] + 49'(xb_r[j]);
    for (int j = 0; j < 2; j++) ysum[j] = ya_r[j] + 49'(yb_r[j]);
    zsum = za_r + 49'(zb_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        fr0_r[k]   <= fr0_c[k];
        fr1_r[k]   <= fr1_c[k];
        f_r[k]     <= f_c[k];
        ff_r[k]    <= ff_c[k];
        prod_r[k]  <= prod_c[k];
        u_p[1][k]  <= u_c[k];
        np_p[1][k] <= np_c[k];
      end
      acc_p[0] <= in_acc;
      for (int s = 1; s <= 10; s++) acc_p[s] <= acc_p[s-1];
      for (int s = 2; s <= 9; s++)  u_p[s]   <= u_p[s-1];
      for (int s = 2; s <= 11; s++) np_p[s]  <= np_p[s-1];
      // x blend
      for (int j = 0; j < 4; j++) begin
        xa_r[j] <= 49'(h[2*j]) * 49'(vnf_pkg::ONE_Q24 - 25'(u_p[5][0]));
        xb_r[j] <= 48'(h[2*j+1]) * 48'(u_p[5][0]);
        xv_r[j] <= xsum[j][47:24];
      end
      // y blend
      for (int j = 0; j < 2; j++) begin
        ya_r[j] <= 49'(xv_r[2*j]) * 49'(vnf_pkg::ONE_Q24 - 25'(u_p[7][1]));
        yb_r[j] <= 48'(xv_r[2*j+1]) * 48'(u_p[7][1]);
        yv_r[j] <= ysum[j][47:24];
      end
      // z blend and octave accumulate (Horner form: acc = 2*acc + n)
      za_r      <= 49'(yv_r[0]) * 49'(vnf_pkg::ONE_Q24 - 25'(u_p[9][2]));
      zb_r      <= 48'(yv_r[1]) * 48'(u_p[9][2]);
      acc_out_r <= {acc_p[10][AW-2:0], 1'b0} + AW'(zsum[47:24]);
    end
  end

  assign out_valid = v_r[LAT-1];
  assign out_px    = np_p[11][0];
  assign out_py    = np_p[11][1];
  assign out_pz    = np_p[11][2];
  assign out_acc   = acc_out_r;

endmodule
`default_nettype wire

/* rtl/core/vnf_norm.sv */
// Two-stage restoring divide of the octave sum by the total amplitude, to Q0.16.
`timescale 1ns / 1ps
`default_nettype none
module vnf_norm #(
  parameter int OCTAVES = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [OCTAVES+23:0]   in_acc,
  output logic                       out_valid,
  output logic [15:0]                out_noise
);

  localparam int NW = OCTAVES + 16;
  localparam logic [OCTAVES:0] DEN = (OCTAVES+1)'((1 << OCTAVES) - 1);

  logic [NW-1:0] num;
  assign num = in_acc[OCTAVES+23:8];

  logic [OCTAVES-1:0] ra_r;
  logic [7:0]         qa_r;
  logic [7:0]         nlo_r;
  logic               va_r;
  logic [15:0]        q_r;
  logic               vb_r;

  logic [OCTAVES-1:0] ra_c;
  logic [7:0]         qa_c;
  logic [7:0]         qb_c;

  // high quotient byte
  always_comb begin
    logic [OCTAVES:0] r_ext;
    logic [OCTAVES-1:0] r;
    r = num[NW-1:16];
    for (int j = 7; j >= 0; j--) begin
      r_ext = {r, num[j+8]};
      qa_c[j] = (r_ext >= DEN);
      if (qa_c[j]) r_ext = r_ext - DEN;
      r = r_ext[OCTAVES-1:0];
    end
    ra_c = r;
  end

  // low quotient byte
  always_comb begin
    logic [OCTAVES:0] r_ext;
    logic [OCTAVES-1:0] r;
    r = ra_r;
    for (int j = 7; j >= 0; j--) begin
      r_ext = {r, nlo_r[j]};
      qb_c[j] = (r_ext >= DEN);
      if (qb_c[j]) r_ext = r_ext - DEN;
      r = r_ext[OCTAVES-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra_r  <= ra_c;
      qa_r  <= qa_c;
      nlo_r <= num[7:0];
      q_r   <= {qa_r, qb_c};
    end
  end

  assign out_valid = vb_r;
  assign out_noise = q_r;

endmodule
`default_nettype wire

/* tb/vnf_checker.sv */
// Checker for the value-noise fBm core: predicts each point's noise word and compares.
`timescale 1ns / 1ps
module vnf_checker #(
  parameter int OCTAVES = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [15:0]        out_noise_value,
  output int                 fail_count,
  output int                 pending
);

  // expected words in flight, ring indexed by running counts
  logic [15:0] want_mem [1024];
  int wr_idx = 0;
  int rd_idx = 0;

  function automatic logic [63:0] lat_hash(input logic [63:0] nx, input logic [63:0] ny,
                                           input logic [63:0] nz);
    logic [63:0] a, b, c, d, x, y, z, m;
    m = 64'd442811128;
    a = ((nx * m) & 64'hFFFF_FFFF) >> 8;
    b = ((ny * m) & 64'hFFFF_FFFF) >> 8;
    c = ((nz * m) & 64'hFFFF_FFFF) >> 8;
    d = (a * (b + 64'd559184609) + b * (c + 64'd559184609) + c * (a + 64'd559184609)) >> 24;
    x = a + d;
    y = b + d;
    z = c + d;
    return (((x + y) * z) >> 24) & 64'hFF_FFFF;
  endfunction

  function automatic logic [63:0] lerp24(input logic [63:0] x, input logic [63:0] y,
                                         input logic [63:0] t);
    return (x * ((64'd1 << 24) - t) + y * t) >> 24;
  endfunction

  function automatic logic [15:0] fbm_noise(input logic signed [31:0] px,
                                            input logic signed [31:0] py,
                                            input logic signed [31:0] pz);
    logic signed [63:0] p[3];
    logic signed [63:0] off[3];
    logic [63:0] lat[3], u[3], n[8], f, f2, acc, den, val;
    off[0] = 64'sd1120666;
    off[1] = 64'sd2077491;
    off[2] = 64'sd740557;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    acc = 0;
    for (int o = 0; o < OCTAVES; o++) begin
      for (int k = 0; k < 3; k++) begin
        lat[k] = p[k] >>> 16;
        f = (p[k] & 64'hFFFF) << 8;
        f2 = (f * f) >> 24;
        u[k] = (f2 * (64'd3 * (64'd1 << 24) - 2 * f)) >> 24;
      end
      for (int i = 0; i < 8; i++)
        n[i] = lat_hash(lat[0] + (i & 1), lat[1] + ((i >> 1) & 1), lat[2] + ((i >> 2) & 1));
      acc += lerp24(lerp24(lerp24(n[0], n[1], u[0]), lerp24(n[2], n[3], u[0]), u[1]),
                    lerp24(lerp24(n[4], n[5], u[0]), lerp24(n[6], n[7], u[0]), u[1]),
                    u[2]) << (OCTAVES - 1 - o);
      // wrap-free: |p| stays under 2^40 for 8 octaves, so the product fits in 64 bits
      for (int k = 0; k < 3; k++)
        p[k] = ((p[k] * 64'sd133038) >>> 16) + off[k];
    end
    if (OCTAVES < 1) return 16'd0;
    den = ((64'd1 << OCTAVES) - 1) << 8;
    val = acc / den;
    return (val > 64'd65535) ? 16'hFFFF : val[15:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  assign pending = wr_idx - rd_idx;

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (wr_idx == rd_idx)
          report_mismatch($sformatf("unexpected word %h", out_noise_value));
        else begin
          logic [15:0] want;
          want = want_mem[rd_idx % 1024];
          rd_idx = rd_idx + 1;
          if (want !== out_noise_value)
            report_mismatch($sformatf("noise_value got %h want %h", out_noise_value, want));
        end
      end
      if (in_valid && in_ready) begin
        want_mem[wr_idx % 1024] = fbm_noise(in_point_x, in_point_y, in_point_z);
        wr_idx = wr_idx + 1;
      end
    end
  end

endmodule

/* tb/tb_value_noise_fbm_3d_core.sv */
// Testbench top for the value-noise fBm core: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_value_noise_fbm_3d_core;

  localparam int LATENCY = 12 * 5 + 2;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_noise_value;
  int fail_count, pending;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  value_noise_fbm_3d_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_ready(out_ready), .out_noise_value(out_noise_value)
  );

  vnf_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_ready(out_ready), .out_noise_value(out_noise_value),
    .fail_count(fail_count), .pending(pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Random coordinate: full 32-bit range, or near zero / lattice edges.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 20'hFFFFF)) - 32'sd524288;
      2: return {16'($urandom_range(0, 16'hFFFF)), 16'(16'hFFFF - $urandom_range(0, 3))};
      default: return {16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 3))};
    endcase
  endfunction

  // Present one word at the falling edge, hold until accepted; valid stays
  // high afterwards until the next gap or hold-off drops it.
  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_ready === 1'b1));
    @(negedge clk);
  endtask

  // Receiver: random back-pressure, with quiet stretches of constant ready.
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 9) < 3) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 200)) @(negedge clk);
      end
      g = gap_len();
      out_ready <= (g == 0);
      repeat (g) @(negedge clk);
      out_ready <= 1'b1;
    end
  end

  // Watchdog: cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [31:0] edge_vals[8];
    edge_vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h0000_FFFF, 32'hFFFF_0000, 32'h0001_0000, 32'h5555_AAAA};
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    // directed: field extremes and all-bit patterns
    for (int i = 0; i < 8; i++)
      send_point(edge_vals[i], edge_vals[(i + 3) % 8], edge_vals[(i + 5) % 8]);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'hAAAA_5555, 32'h0F0F_F0F0, 32'hF0F0_0F0F);
    // random points
    for (int i = 0; i < 1000; i++) begin
      send_point(rand_coord(), rand_coord(), rand_coord());
      // sender holds off until the pipe drains
      if (i == 400 || i == 750) begin
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* value_noise_fbm_3d_core.f */
rtl/core/vnf_pkg.sv
rtl/core/vnf_hash.sv
rtl/core/vnf_octave.sv
rtl/core/vnf_norm.sv
rtl/core/value_noise_fbm_3d_core.sv
tb/vnf_checker.sv
tb/tb_value_noise_fbm_3d_core.sv
